// File: sv/assert_macros.svh
// Assertion macros shared by the valve controller RTL.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define CHK_SAME(label, ante, cons, msg) \
	`CHK_ALWAYS(label, (ante) |-> (cons), msg)

// Checks that a condition implies a consequence in the next cycle.
`define CHK_NEXT(label, ante, cons, msg) \
	`CHK_ALWAYS(label, (ante) |=> (cons), msg)

`endif

// File: sv/mctv_pkg.sv
// Package for the multi-channel timed valve controller.
// Holds field widths, command and status codes, register indexes and reset values; no dependencies.
package mctv_pkg;

	localparam int TIME_W       = 32;
	localparam int FIELD_VALVES = 6;
	localparam int VALVE_W      = 3;
	localparam int CHAN_W       = 3;
	localparam int STATUS_W     = 3;
	localparam int CFG_INDEX_W  = 8;
	localparam int CFG_DATA_W   = 32;
	localparam int RELAY_MAP_W  = FIELD_VALVES * CHAN_W;
	localparam int NUM_VALVES_DEFAULT = 6;

	// Command codes of the input item.
	localparam logic CMD_OPEN = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OPENED       = 3'd0,
		ST_NOT_READY    = 3'd1,
		ST_NOT_ASSIGNED = 3'd2,
		ST_ALREADY_OPEN = 3'd3,
		ST_TICK_DONE    = 3'd4
	} status_t;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_START_DELAY  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DURATION = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRESENT_MASK = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_RELAY_MAP    = 8'd3;

	// Configuration reset values; the relay map sends valve v to channel v.
	localparam logic [TIME_W-1:0]       START_DELAY_RST  = 32'd0;
	localparam logic [TIME_W-1:0]       MAX_DURATION_RST = 32'd600000;
	localparam logic [FIELD_VALVES-1:0] PRESENT_RST      = 6'd0;
	localparam logic [RELAY_MAP_W-1:0]  RELAY_MAP_RST    = 18'd181896;

endpackage

// File: sv/multi_channel_timed_valve_control_top.sv
// Top level of the multi-channel timed valve controller (one-shot timer per valve).
// Depends on mctv_pkg and on assert_macros.svh for its checks.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | cmd, valve, duration_ms
//   rsp     | out       | rsp_valid/rsp_stall  | status, was_clamped, open_mask,
//           |           |                      | closed_now, relay_drive
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Each request transaction's result is in the response register
// on the next edge, and a new request is taken every cycle while responses drain.
// The per-valve deadline compares and the time increment sit between the state
// registers and the response register; that single stage sets the rate.
// Reset clears time, the ready flag, all open flags and the response valid, and loads
// the configuration reset values. A stalled response holds the request side off.
module multi_channel_timed_valve_control_top #(
	parameter int NUM_VALVES = mctv_pkg::NUM_VALVES_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Request channel.
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic                               cmd,
	input  logic [mctv_pkg::VALVE_W-1:0]       valve,
	input  logic [mctv_pkg::TIME_W-1:0]        duration_ms,
	// Response channel.
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [mctv_pkg::STATUS_W-1:0]      status,
	output logic                               was_clamped,
	output logic [mctv_pkg::FIELD_VALVES-1:0]  open_mask,
	output logic [mctv_pkg::FIELD_VALVES-1:0]  closed_now,
	output logic [mctv_pkg::FIELD_VALVES-1:0]  relay_drive,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mctv_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mctv_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mctv_pkg::*;

`include "assert_macros.svh"

	// Valves at or above the field width can never be opened, so only the
	// valves that fit in the result fields get timer storage.
	localparam int NV_LIVE = (NUM_VALVES < FIELD_VALVES) ? NUM_VALVES : FIELD_VALVES;

	// Configuration registers.
	logic [TIME_W-1:0]       start_delay_q;
	logic [TIME_W-1:0]       max_duration_q;
	logic [FIELD_VALVES-1:0] present_q;
	logic [RELAY_MAP_W-1:0]  relay_map_q;

	// Timer state.
	logic [TIME_W-1:0]  time_q;
	logic               ready_q;
	logic [NV_LIVE-1:0] open_q;
	logic [TIME_W-1:0]  deadline_q [NV_LIVE];

	// Response register.
	logic                    rsp_valid_q;
	status_t                 status_q;
	logic                    clamped_q;
	logic [FIELD_VALVES-1:0] open_mask_q;
	logic [FIELD_VALVES-1:0] closed_q;
	logic [FIELD_VALVES-1:0] drive_q;

	// Next-state logic.
	logic               req_take;
	logic [TIME_W-1:0]  time_inc;
	logic [TIME_W-1:0]  diff;
	logic [TIME_W-1:0]  dur_eff;
	logic               dur_over;
	logic [NV_LIVE-1:0] sel;
	logic [NV_LIVE-1:0] expired;
	logic               hit_present;
	logic               hit_open;
	logic [NV_LIVE-1:0] open_next;
	logic [NV_LIVE-1:0] closed_next;
	logic [NV_LIVE-1:0] opening;
	logic               ready_next;
	status_t            status_next;
	logic               clamped_next;
	logic [FIELD_VALVES-1:0] drive_next;
	logic [CHAN_W-1:0]  chan;

	// The response register is free when empty or being taken this cycle.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign req_take  = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	assign time_inc = time_q + 1'b1;
	assign dur_over = duration_ms > max_duration_q;
	assign dur_eff  = dur_over ? max_duration_q : duration_ms;

	always_comb begin
		diff        = '0;
		sel         = '0;
		expired     = '0;
		hit_present = 1'b0;
		hit_open    = 1'b0;
		for (int v = 0; v < NV_LIVE; v++) begin
			// A deadline has passed once time minus deadline is not negative.
			diff       = time_inc - deadline_q[v];
			expired[v] = open_q[v] && !diff[TIME_W-1];
			sel[v]     = (valve == VALVE_W'(v));
			if (sel[v] && present_q[v]) begin
				hit_present = 1'b1;
			end
			if (sel[v] && open_q[v]) begin
				hit_open = 1'b1;
			end
		end
	end

	always_comb begin
		open_next    = open_q;
		closed_next  = '0;
		opening      = '0;
		ready_next   = ready_q;
		clamped_next = 1'b0;
		status_next  = ST_TICK_DONE;
		if (cmd == CMD_TICK) begin
			if (time_inc >= start_delay_q) begin
				ready_next = 1'b1;
			end
			closed_next = expired;
			open_next   = open_q & ~expired;
		end else if (!ready_q) begin
			status_next = ST_NOT_READY;
		end else if (!hit_present) begin
			status_next = ST_NOT_ASSIGNED;
		end else if (hit_open) begin
			status_next = ST_ALREADY_OPEN;
		end else begin
			status_next  = ST_OPENED;
			clamped_next = dur_over;
			opening      = sel;
			open_next    = open_q | sel;
		end
	end

	// A relay channel is driven while any open valve maps to it; codes 6 and 7 drive nothing.
	always_comb begin
		drive_next = '0;
		chan       = '0;
		for (int v = 0; v < NV_LIVE; v++) begin
			chan = relay_map_q[v*CHAN_W +: CHAN_W];
			if (open_next[v] && (chan < CHAN_W'(FIELD_VALVES))) begin
				drive_next[chan] = 1'b1;
			end
		end
	end

	// Configuration writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q  <= START_DELAY_RST;
			max_duration_q <= MAX_DURATION_RST;
			present_q      <= PRESENT_RST;
			relay_map_q    <= RELAY_MAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_DELAY:  start_delay_q  <= cfg_data;
				CFG_MAX_DURATION: max_duration_q <= cfg_data;
				CFG_PRESENT_MASK: present_q      <= cfg_data[FIELD_VALVES-1:0];
				CFG_RELAY_MAP:    relay_map_q    <= cfg_data[RELAY_MAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Timer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			ready_q <= 1'b0;
			open_q  <= '0;
		end else if (req_take) begin
			if (cmd == CMD_TICK) begin
				time_q <= time_inc;
			end
			ready_q <= ready_next;
			open_q  <= open_next;
		end
	end

	// Deadlines are only read while their valve is open, so they need no reset.
	always_ff @(posedge clk) begin
		for (int v = 0; v < NV_LIVE; v++) begin
			if (req_take && opening[v]) begin
				deadline_q[v] <= time_q + dur_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			status_q    <= status_next;
			clamped_q   <= clamped_next;
			open_mask_q <= FIELD_VALVES'(open_next);
			closed_q    <= FIELD_VALVES'(closed_next);
			drive_q     <= drive_next;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign was_clamped = clamped_q;
	assign open_mask   = open_mask_q;
	assign closed_now  = closed_q;
	assign relay_drive = drive_q;

	// The ready flag never clears once set.
	`CHK_NEXT(a_ready_sticky, ready_q, ready_q, "ready flag cleared")
	// Every accepted request leaves a response behind.
	`CHK_NEXT(a_req_gives_rsp, req_take, rsp_valid, "accepted request lost its response")
	// A valve closed by expiry is not reported open in the same response.
	`CHK_SAME(a_closed_not_open, rsp_valid, (closed_now & open_mask) == '0, "closed valve still open")
	// Only ticks close valves.
	`CHK_SAME(a_open_no_close, rsp_valid && status != ST_TICK_DONE, closed_now == '0, "close outside tick")

endmodule
